>>> rtl/gwae_pkg.sv
package gwae_pkg;

  // default build parameters
  localparam int unsigned GroupSlotsDef     = 16;
  localparam int unsigned PureAudioLimitDef = 128;
  localparam int unsigned MaxTimeFloorDef   = 5000;

  // field and counter widths
  localparam int unsigned TOT_W    = 20;
  localparam int unsigned GRP_W    = 16;
  localparam int unsigned ASV_W    = 8;
  localparam int unsigned EVC_W    = 5;
  localparam int unsigned CFG_IX_W = 8;
  localparam int unsigned CFG_D_W  = 32;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned FRM_W    = 20;

  // divider sizes: count times scale over rate
  localparam int unsigned DVD_W = 41;
  localparam int unsigned DVS_W = 20;

  // scale factors and default rate
  localparam logic [DVD_W-1:0] K_AAC   = DVD_W'(1024 * 1000);
  localparam logic [DVD_W-1:0] K_MP3   = DVD_W'(1152 * 1000);
  localparam logic [DVD_W-1:0] K_VIDEO = DVD_W'(1000 * 1000);
  localparam logic [DVS_W-1:0] RATE_DEFAULT = DVS_W'(44100);

  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [GRP_W-1:0] GRP_MAX = '1;
  localparam logic [ASV_W-1:0] ASV_MAX = '1;
  localparam logic [EVC_W-1:0] EVC_MAX = '1;

  // input codes
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic MEDIA_VIDEO = 1'b1;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_CACHE_ENABLE = 8'd0,
    REG_MIN_TIME     = 8'd1,
    REG_MAX_TIME     = 8'd2,
    REG_AUDIO_AAC    = 8'd3,
    REG_SAMPLE_RATE  = 8'd4,
    REG_FRAME_RATE   = 8'd5,
    REG_CODEC_OK     = 8'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_STORED  = 2'd0,
    VERDICT_DROPPED = 2'd1,
    VERDICT_CLEARED = 2'd2,
    VERDICT_FLUSHED = 2'd3
  } verdict_e;

  // division operand select
  typedef enum logic [1:0] {
    DSEL_TOT_AUDIO = 2'd0,
    DSEL_TOT_VIDEO = 2'd1,
    DSEL_GRP_AUDIO = 2'd2,
    DSEL_GRP_VIDEO = 2'd3
  } dsel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_KEV_RD,
    S_KEV,
    S_OPEN,
    S_LINK_RD,
    S_LINK,
    S_CHK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_REM,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     latch_in;
    logic     clear_win;
    logic     asv_inc;
    logic     evict;
    logic     open_grp;
    logic     link;
    logic     rd_oldest;
    logic     rd_tail;
    logic     div_start;
    logic     div_store;
    dsel_e    div_sel;
    logic     rem_calc;
    logic     out_load;
    verdict_e verdict;
  } cmd_t;

  typedef struct packed {
    logic cache_en;
    logic is_flush;
    logic is_video;
    logic is_key;
    logic codec_ok;
    logic no_groups;
    logic full;
    logic no_video_total;
    logic asv_over;
    logic div_done;
    logic evict_hit;
  } status_t;

endpackage

>>> rtl/gop_window_admit_evict.sv
// channel | direction | handshake             | payload
// input   | in        | in_valid_i/in_stall_o | kind_i, media_type_i, is_keyframe_i
// result  | out       | out_valid_o/out_stall_i | verdict_o, groups_evicted_o,
//         |           |                       | group_count_o, video/audio_frames_o
// config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a dropped, flushed or cleared item runs no eviction test; a stored one runs
// one eviction test per group trimmed, plus a final test, or no final test
// when trimming empties the window
// each test runs four 41-step divisions on the one bit-serial divider
// reset clears the window and loads register defaults, no memory sweep
// one transaction in flight; the next is accepted while a result waits
module gop_window_admit_evict #(
  parameter int unsigned GROUP_SLOTS       = gwae_pkg::GroupSlotsDef,
  parameter int unsigned PURE_AUDIO_LIMIT  = gwae_pkg::PureAudioLimitDef,
  parameter int unsigned MAX_TIME_FLOOR_MS = gwae_pkg::MaxTimeFloorDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic                          media_type_i,
  input  logic                          is_keyframe_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    verdict_o,
  output logic [gwae_pkg::EVC_W-1:0]    groups_evicted_o,
  output logic [gwae_pkg::EVC_W-1:0]    group_count_o,
  output logic [gwae_pkg::TOT_W-1:0]    video_frames_o,
  output logic [gwae_pkg::TOT_W-1:0]    audio_frames_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gwae_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic [gwae_pkg::CFG_D_W-1:0]  cfg_data_i
);
  import gwae_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  gwae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gwae_dp #(
    .GROUP_SLOTS       (GROUP_SLOTS),
    .PURE_AUDIO_LIMIT  (PURE_AUDIO_LIMIT),
    .MAX_TIME_FLOOR_MS (MAX_TIME_FLOOR_MS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .media_type_i     (media_type_i),
    .is_keyframe_i    (is_keyframe_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .verdict_o        (verdict_o),
    .groups_evicted_o (groups_evicted_o),
    .group_count_o    (group_count_o),
    .video_frames_o   (video_frames_o),
    .audio_frames_o   (audio_frames_o)
  );

endmodule

>>> rtl/gwae_div.sv
module gwae_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gwae_pkg::DVD_W-1:0] dividend_i,
  input  logic [gwae_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [gwae_pkg::DVD_W-1:0] quotient_o
);
  import gwae_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // a new division only starts on an idle unit
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  // completion follows the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy_q) |-> done_q)
    else $error("divider stopped without done");

endmodule

>>> rtl/gwae_dp.sv
module gwae_dp #(
  parameter int unsigned GROUP_SLOTS       = gwae_pkg::GroupSlotsDef,
  parameter int unsigned PURE_AUDIO_LIMIT  = gwae_pkg::PureAudioLimitDef,
  parameter int unsigned MAX_TIME_FLOOR_MS = gwae_pkg::MaxTimeFloorDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gwae_pkg::cmd_t                cmd_i,
  output gwae_pkg::status_t             status_o,
  input  logic                          kind_i,
  input  logic                          media_type_i,
  input  logic                          is_keyframe_i,
  input  logic                          cfg_we_i,
  input  logic [gwae_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic [gwae_pkg::CFG_D_W-1:0]  cfg_data_i,
  output logic [1:0]                    verdict_o,
  output logic [gwae_pkg::EVC_W-1:0]    groups_evicted_o,
  output logic [gwae_pkg::EVC_W-1:0]    group_count_o,
  output logic [gwae_pkg::TOT_W-1:0]    video_frames_o,
  output logic [gwae_pkg::TOT_W-1:0]    audio_frames_o
);
  import gwae_pkg::*;

  localparam int unsigned SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int unsigned HW = $clog2(GROUP_SLOTS + 1);
  localparam int unsigned MW = 2 * GRP_W;

  // configuration registers
  logic               en_q, aac_q, codec_q;
  logic [CFG_D_W-1:0] min_q, max_q;
  logic [RATE_W-1:0]  rate_q;
  logic [FRM_W-1:0]   frm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      min_q   <= '0;
      max_q   <= CFG_D_W'(5000);
      aac_q   <= 1'b0;
      rate_q  <= RATE_W'(44100);
      frm_q   <= '0;
      codec_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CACHE_ENABLE: en_q    <= cfg_data_i[0];
        REG_MIN_TIME:     min_q   <= cfg_data_i;
        REG_MAX_TIME:     max_q   <= cfg_data_i;
        REG_AUDIO_AAC:    aac_q   <= cfg_data_i[0];
        REG_SAMPLE_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
        REG_FRAME_RATE:   frm_q   <= cfg_data_i[FRM_W-1:0];
        REG_CODEC_OK:     codec_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // window state
  logic             kind_q, video_q, key_q;
  logic [SW-1:0]    oldest_q, oldest_d;
  logic [HW-1:0]    groups_q, groups_d;
  logic [TOT_W-1:0] tv_q, tv_d, ta_q, ta_d;
  logic [ASV_W-1:0] asv_q, asv_d;
  logic [EVC_W-1:0] evc_q, evc_d;

  // group count memory, video count high, audio count low
  logic [MW-1:0] mem [GROUP_SLOTS];
  logic [MW-1:0] rd_q;
  logic [MW-1:0] wdata;
  logic [SW-1:0] waddr, raddr;
  logic          we, re;

  logic [SW:0]   sum_new, sum_tail;
  logic [SW-1:0] slot_new, slot_tail, oldest_nx;
  logic [GRP_W-1:0] rv, ra;
  logic [ASV_W-1:0] asv_inc;

  // ring slot arithmetic
  always_comb begin
    sum_new  = (SW+1)'(oldest_q) + (SW+1)'(groups_q);
    sum_tail = (SW+1)'(oldest_q) + (SW+1)'(groups_q) - (SW+1)'(1);
    slot_new  = (sum_new >= (SW+1)'(GROUP_SLOTS)) ?
                SW'(sum_new - (SW+1)'(GROUP_SLOTS)) : sum_new[SW-1:0];
    slot_tail = (sum_tail >= (SW+1)'(GROUP_SLOTS)) ?
                SW'(sum_tail - (SW+1)'(GROUP_SLOTS)) : sum_tail[SW-1:0];
    oldest_nx = (oldest_q == SW'(GROUP_SLOTS - 1)) ? '0 : oldest_q + SW'(1);
    rv      = rd_q[MW-1:GRP_W];
    ra      = rd_q[GRP_W-1:0];
    asv_inc = (asv_q == ASV_MAX) ? asv_q : asv_q + ASV_W'(1);
  end

  // state updates
  always_comb begin
    oldest_d = oldest_q;
    groups_d = groups_q;
    tv_d     = tv_q;
    ta_d     = ta_q;
    asv_d    = asv_q;
    evc_d    = evc_q;
    we       = 1'b0;
    waddr    = slot_tail;
    wdata    = rd_q;
    if (cmd_i.latch_in) begin
      evc_d = '0;
    end
    if (cmd_i.clear_win) begin
      oldest_d = '0;
      groups_d = '0;
      tv_d     = '0;
      ta_d     = '0;
      asv_d    = '0;
    end else if (cmd_i.asv_inc) begin
      asv_d = asv_inc;
    end else if (cmd_i.evict) begin
      tv_d     = (tv_q > TOT_W'(rv)) ? tv_q - TOT_W'(rv) : '0;
      ta_d     = (ta_q > TOT_W'(ra)) ? ta_q - TOT_W'(ra) : '0;
      oldest_d = oldest_nx;
      groups_d = (groups_q != '0) ? groups_q - HW'(1) : groups_q;
      evc_d    = (evc_q == EVC_MAX) ? evc_q : evc_q + EVC_W'(1);
    end else if (cmd_i.open_grp) begin
      // new group already holding its keyframe
      we       = 1'b1;
      waddr    = slot_new;
      wdata    = {GRP_W'(1), GRP_W'(0)};
      groups_d = groups_q + HW'(1);
      tv_d     = (tv_q == TOT_MAX) ? tv_q : tv_q + TOT_W'(1);
      asv_d    = '0;
    end else if (cmd_i.link) begin
      we    = 1'b1;
      waddr = slot_tail;
      if (video_q == MEDIA_VIDEO) begin
        wdata = {((rv == GRP_MAX) ? rv : rv + GRP_W'(1)), ra};
        tv_d  = (tv_q == TOT_MAX) ? tv_q : tv_q + TOT_W'(1);
        asv_d = '0;
      end else begin
        wdata = {rv, ((ra == GRP_MAX) ? ra : ra + GRP_W'(1))};
        ta_d  = (ta_q == TOT_MAX) ? ta_q : ta_q + TOT_W'(1);
      end
    end
  end

  assign re    = cmd_i.rd_oldest | cmd_i.rd_tail;
  assign raddr = cmd_i.rd_oldest ? oldest_q : slot_tail;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      groups_q <= '0;
      tv_q     <= '0;
      ta_q     <= '0;
      asv_q    <= '0;
      evc_q    <= '0;
    end else begin
      oldest_q <= oldest_d;
      groups_q <= groups_d;
      tv_q     <= tv_d;
      ta_q     <= ta_d;
      asv_q    <= asv_d;
      evc_q    <= evc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q  <= kind_i;
      video_q <= media_type_i;
      key_q   <= is_keyframe_i;
    end
  end

  // duration operand and shared divider
  logic [TOT_W-1:0] dcnt;
  logic [DVD_W-1:0] dscale, dividend;
  logic [DVS_W-1:0] divisor;
  logic             ddone;
  logic [DVD_W-1:0] quo;
  logic             dvid;

  always_comb begin
    case (cmd_i.div_sel)
      DSEL_TOT_AUDIO: dcnt = ta_q;
      DSEL_TOT_VIDEO: dcnt = tv_q;
      DSEL_GRP_AUDIO: dcnt = TOT_W'(ra);
      DSEL_GRP_VIDEO: dcnt = TOT_W'(rv);
      default:        dcnt = '0;
    endcase
    dvid     = (cmd_i.div_sel == DSEL_TOT_VIDEO) || (cmd_i.div_sel == DSEL_GRP_VIDEO);
    dscale   = dvid ? K_VIDEO : (aac_q ? K_AAC : K_MP3);
    dividend = DVD_W'(dcnt) * dscale;
    if (dvid) begin
      divisor = DVS_W'(frm_q);
    end else begin
      divisor = (rate_q == '0) ? RATE_DEFAULT : DVS_W'(rate_q);
    end
  end

  gwae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (ddone),
    .quotient_o (quo)
  );

  // durations and eviction test
  logic [DVD_W-1:0] ca_q, cv_q, da_q, dv_q, rem_q, tmax_q;
  logic [DVD_W-1:0] rem_a, rem_v, cap;
  logic             vzero;

  assign vzero = (frm_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DSEL_TOT_AUDIO: ca_q <= quo;
        DSEL_TOT_VIDEO: cv_q <= vzero ? '0 : quo;
        DSEL_GRP_AUDIO: da_q <= quo;
        DSEL_GRP_VIDEO: dv_q <= vzero ? '0 : quo;
        default: ;
      endcase
    end
    if (cmd_i.rem_calc) begin
      rem_q  <= (rem_a > rem_v) ? rem_a : rem_v;
      tmax_q <= (ca_q > cv_q) ? ca_q : cv_q;
    end
  end

  always_comb begin
    rem_a = (ca_q > da_q) ? ca_q - da_q : '0;
    rem_v = (cv_q > dv_q) ? cv_q - dv_q : '0;
    cap   = (max_q > CFG_D_W'(MAX_TIME_FLOOR_MS)) ? DVD_W'(max_q) :
            DVD_W'(MAX_TIME_FLOOR_MS);
  end

  // status to the controller
  always_comb begin
    status_o.cache_en       = en_q;
    status_o.is_flush       = (kind_q == KIND_FLUSH);
    status_o.is_video       = (video_q == MEDIA_VIDEO);
    status_o.is_key         = key_q;
    status_o.codec_ok       = codec_q;
    status_o.no_groups      = (groups_q == '0);
    status_o.full           = (groups_q >= HW'(GROUP_SLOTS));
    status_o.no_video_total = (tv_q == '0);
    status_o.asv_over       = (((video_q == MEDIA_VIDEO) ? asv_q : asv_inc) >
                               ASV_W'(PURE_AUDIO_LIMIT));
    status_o.div_done       = ddone;
    status_o.evict_hit      = (rem_q > DVD_W'(min_q)) || (tmax_q > cap);
  end

  // result registers
  verdict_e         verdict_q;
  logic [EVC_W-1:0] evo_q, gco_q;
  logic [TOT_W-1:0] tvo_q, tao_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      verdict_q <= cmd_i.verdict;
      evo_q     <= evc_q;
      gco_q     <= EVC_W'(groups_q);
      tvo_q     <= tv_q;
      tao_q     <= ta_q;
    end
  end

  assign verdict_o        = verdict_q;
  assign groups_evicted_o = evo_q;
  assign group_count_o    = gco_q;
  assign video_frames_o   = tvo_q;
  assign audio_frames_o   = tao_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    groups_q <= HW'(GROUP_SLOTS))
    else $error("group count beyond ring size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open_grp |-> groups_q < HW'(GROUP_SLOTS))
    else $error("group opened on full ring");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_win |=> (groups_q == '0) && (tv_q == '0) && (ta_q == '0))
    else $error("window not empty after clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.evict || cmd_i.link) |-> !status_o.no_groups)
    else $error("group access with empty ring");

endmodule

>>> rtl/gwae_ctrl.sv
module gwae_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  gwae_pkg::status_t status_i,
  output gwae_pkg::cmd_t    cmd_o
);
  import gwae_pkg::*;

  state_e   state_q, state_d;
  verdict_e verdict_q, verdict_d;
  dsel_e    sel_q, sel_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    verdict_d = verdict_q;
    sel_d     = sel_q;
    cmd_o     = '0;
    cmd_o.div_sel = sel_q;
    cmd_o.verdict = verdict_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        verdict_d = VERDICT_DROPPED;
        state_d   = S_DONE;
        if (!status_i.cache_en) begin
          verdict_d = VERDICT_DROPPED;
        end else if (status_i.is_flush) begin
          cmd_o.clear_win = 1'b1;
          verdict_d = VERDICT_FLUSHED;
        end else if (status_i.is_video && !status_i.codec_ok) begin
          verdict_d = VERDICT_DROPPED;
        end else if (status_i.is_video && !status_i.is_key && status_i.no_groups) begin
          verdict_d = VERDICT_DROPPED;
        end else if (!status_i.is_video && status_i.no_video_total) begin
          verdict_d = VERDICT_DROPPED;
        end else if (status_i.asv_over) begin
          cmd_o.clear_win = 1'b1;
          verdict_d = VERDICT_CLEARED;
        end else begin
          cmd_o.asv_inc = !status_i.is_video;
          if (status_i.is_video && status_i.is_key) begin
            state_d = status_i.full ? S_KEV_RD : S_OPEN;
          end else if (!status_i.no_groups) begin
            state_d = S_LINK_RD;
          end
        end
      end
      S_KEV_RD: begin
        cmd_o.rd_oldest = 1'b1;
        state_d = S_KEV;
      end
      S_KEV: begin
        cmd_o.evict = 1'b1;
        state_d = S_OPEN;
      end
      S_OPEN: begin
        cmd_o.open_grp = 1'b1;
        state_d = S_CHK;
      end
      S_LINK_RD: begin
        cmd_o.rd_tail = 1'b1;
        state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        verdict_d = VERDICT_STORED;
        if (status_i.no_groups) begin
          cmd_o.clear_win = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_oldest = 1'b1;
          sel_d   = DSEL_TOT_AUDIO;
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == DSEL_GRP_VIDEO) begin
            state_d = S_REM;
          end else begin
            sel_d   = dsel_e'(sel_q + 2'd1);
            state_d = S_DIV_GO;
          end
        end
      end
      S_REM: begin
        cmd_o.rem_calc = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (status_i.evict_hit) begin
          cmd_o.evict = 1'b1;
          state_d = S_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      verdict_q   <= VERDICT_DROPPED;
      sel_q       <= DSEL_TOT_AUDIO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      verdict_q   <= verdict_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result overwritten while stalled");
  // every accepted transaction yields one result before the next is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result not presented after load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_store |-> (state_q == S_DIV_WAIT))
    else $error("quotient stored outside wait");

endmodule
